// ===== sv/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the bounded byte deque: command and status
// codes, cell operations and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W    = 4;
   localparam int BYTE_W   = 8;
   localparam int CAP_W    = 5;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_PEEK_REAR     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_REPLACE_FRONT = 4'd6;
   localparam logic [CMD_W-1:0] CMD_REPLACE_REAR  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SEARCH        = 4'd8;
   localparam logic [CMD_W-1:0] CMD_CLEAR         = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHR,
      CELL_SHL,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [BYTE_W-1:0] wdata;
      logic [BYTE_W-1:0] key;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_WAVE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/bounded_char_deque.sv =====
// Responses: push, front pop/peek, replace, clear, empty refusals and search on
//   an empty deque pass the result stage and the output register, where rsp_valid
//   rises; one item per cycle while rsp_ready keeps the output moving. Rear pop,
//   rear peek and search take their result from the wave that runs one cell per
//   cycle down the chain of DEPTH cells; no new item is taken while a wave runs.
// Reset: synchronous; empties the deque, sets capacity_limit to 16 and drops any
//   pending result. Cell contents are not cleared.
// ----------------------------------------------------------------------------
// bounded_char_deque
// Bounded double-ended byte queue built as a chain of cells, entry i held in
// cell i, with a controller, a result stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_char_deque #(
   parameter int DEPTH = bcd_pkg::DEPTH_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [bcd_pkg::CMD_W-1:0]      req_cmd,
   input  wire  [bcd_pkg::BYTE_W-1:0]     req_data_in,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [bcd_pkg::BYTE_W-1:0]     rsp_data_out,
   output logic [bcd_pkg::POS_W-1:0]      rsp_match_position,
   output logic [bcd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bcd_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic                           rsp_is_empty_flag,
   output logic                           rsp_is_full_flag,
   input  wire                            csr_wr_en,
   input  wire  [bcd_pkg::CAP_W-1:0]      csr_wr_data
);

   localparam int CW   = $clog2(DEPTH+1);
   localparam int CAPW = (CW > bcd_pkg::CAP_W) ? CW : bcd_pkg::CAP_W;
   localparam logic [CW-1:0]   DEPTH_C   = CW'(DEPTH);
   localparam logic [CAPW-1:0] DEPTH_CAP = CAPW'(DEPTH);
   localparam logic [CW-1:0]   ONE_C     = CW'(1);

   // control state
   bcd_pkg::state_type           state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                wave_cnt_ff, wave_cnt_in;
   logic [bcd_pkg::CAP_W-1:0]    cap_ff;
   logic [bcd_pkg::CMD_W-1:0]    cmd_ff;
   logic [bcd_pkg::BYTE_W-1:0]   key_ff;

   // result stage and output register
   logic                         res_valid_ff, res_valid_in;
   logic [bcd_pkg::BYTE_W-1:0]   res_dout_ff, res_dout_in;
   logic [CW-1:0]                res_pos_ff, res_pos_in;
   logic [bcd_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CW-1:0]                res_count_ff;
   logic                         res_empty_ff, res_empty_in;
   logic                         res_full_ff, res_full_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         accept, res_load, res_move, wave_start, wave_done;
   logic                         full_now;
   logic [CAPW-1:0]              eff_cap;
   bcd_pkg::cell_ctrl_type       cell_ctrl;
   logic [CW-1:0]                cell_target;

   logic [bcd_pkg::BYTE_W-1:0]   cell_byte  [DEPTH];
   logic [CW-1:0]                pos_chain  [DEPTH+1];
   logic [bcd_pkg::BYTE_W-1:0]   rbyte_chain[DEPTH+1];

   assign eff_cap   = (CAPW'(cap_ff) > DEPTH_CAP) ? DEPTH_CAP : CAPW'(cap_ff);
   assign full_now  = CAPW'(count_ff) >= eff_cap;
   assign wave_done = (state_ff == bcd_pkg::ST_WAVE) && (wave_cnt_ff == DEPTH_C);
   assign res_move  = res_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == bcd_pkg::ST_IDLE) && (!res_valid_ff || res_move);
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- cell chain
   assign pos_chain[0]   = '0;
   assign rbyte_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [bcd_pkg::BYTE_W-1:0] left_b, right_b;
      if (i == 0) begin : g_first
         assign left_b = cell_ctrl.wdata;
      end else begin : g_mid_l
         assign left_b = cell_byte[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_b = cell_byte[i];
      end else begin : g_mid_r
         assign right_b = cell_byte[i+1];
      end
      bcd_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .target     (cell_target),
         .left_byte  (left_b),
         .right_byte (right_b),
         .pos_prev   (pos_chain[i]),
         .rbyte_prev (rbyte_chain[i]),
         .byte_out   (cell_byte[i]),
         .pos_next   (pos_chain[i+1]),
         .rbyte_next (rbyte_chain[i+1])
      );
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in    = state_ff;
      wave_cnt_in = wave_cnt_ff;
      case (state_ff)
         bcd_pkg::ST_IDLE: begin
            if (wave_start) begin
               state_in    = bcd_pkg::ST_WAVE;
               wave_cnt_in = '0;
            end
         end
         bcd_pkg::ST_WAVE: begin
            if (wave_done) begin
               state_in = bcd_pkg::ST_IDLE;
            end else begin
               wave_cnt_in = wave_cnt_ff + ONE_C;
            end
         end
         default: state_in = bcd_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      cell_ctrl.op    = bcd_pkg::CELL_HOLD;
      cell_ctrl.wdata = req_data_in;
      cell_ctrl.key   = key_ff;
      cell_target     = count_ff;
      count_in        = count_ff;
      wave_start      = 1'b0;
      res_load        = 1'b0;
      res_dout_in     = '0;
      res_pos_in      = '0;
      res_status_in   = bcd_pkg::STATUS_OK;

      if (accept) begin
         res_load = 1'b1;
         case (req_cmd)
            bcd_pkg::CMD_PUSH_FRONT, bcd_pkg::CMD_PUSH_REAR: begin
               if (full_now) begin
                  res_status_in = bcd_pkg::STATUS_FULL;
               end else begin
                  cell_ctrl.op = (req_cmd == bcd_pkg::CMD_PUSH_FRONT) ?
                                 bcd_pkg::CELL_SHR : bcd_pkg::CELL_LOAD;
                  count_in     = count_ff + ONE_C;
               end
            end
            bcd_pkg::CMD_POP_FRONT, bcd_pkg::CMD_PEEK_FRONT,
            bcd_pkg::CMD_REPLACE_FRONT, bcd_pkg::CMD_REPLACE_REAR: begin
               if (count_ff == '0) begin
                  res_status_in = bcd_pkg::STATUS_EMPTY;
               end else if (req_cmd == bcd_pkg::CMD_POP_FRONT) begin
                  res_dout_in  = cell_byte[0];
                  cell_ctrl.op = bcd_pkg::CELL_SHL;
                  count_in     = count_ff - ONE_C;
               end else if (req_cmd == bcd_pkg::CMD_PEEK_FRONT) begin
                  res_dout_in = cell_byte[0];
               end else if (req_cmd == bcd_pkg::CMD_REPLACE_FRONT) begin
                  cell_ctrl.op = bcd_pkg::CELL_LOAD;
                  cell_target  = '0;
               end else begin
                  cell_ctrl.op = bcd_pkg::CELL_LOAD;
                  cell_target  = count_ff - ONE_C;
               end
            end
            bcd_pkg::CMD_POP_REAR, bcd_pkg::CMD_PEEK_REAR: begin
               if (count_ff == '0) begin
                  res_status_in = bcd_pkg::STATUS_EMPTY;
               end else begin
                  wave_start = 1'b1;
                  res_load   = 1'b0;
               end
            end
            bcd_pkg::CMD_SEARCH: begin
               if (count_ff == '0) begin
                  res_status_in = bcd_pkg::STATUS_NOT_FOUND;
               end else begin
                  wave_start = 1'b1;
                  res_load   = 1'b0;
               end
            end
            bcd_pkg::CMD_CLEAR: count_in = '0;
            default:            count_in = count_ff;
         endcase
      end else if (wave_done) begin
         // the wave has reached the end of the chain: collect its result
         res_load = 1'b1;
         case (cmd_ff)
            bcd_pkg::CMD_POP_REAR: begin
               res_dout_in = rbyte_chain[DEPTH];
               count_in    = count_ff - ONE_C;
            end
            bcd_pkg::CMD_PEEK_REAR: res_dout_in = rbyte_chain[DEPTH];
            bcd_pkg::CMD_SEARCH: begin
               res_pos_in    = pos_chain[DEPTH];
               res_status_in = (pos_chain[DEPTH] == '0) ? bcd_pkg::STATUS_NOT_FOUND :
                                                          bcd_pkg::STATUS_OK;
            end
            default: res_dout_in = '0;
         endcase
      end

      res_empty_in = (count_in == '0);
      res_full_in  = CAPW'(count_in) >= eff_cap;

      res_valid_in = res_valid_ff;
      if (res_move) begin
         res_valid_in = 1'b0;
      end
      if (res_load) begin
         res_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcd_pkg::ST_IDLE;
         count_ff     <= '0;
         wave_cnt_ff  <= '0;
         cap_ff       <= bcd_pkg::CAP_RESET;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wave_cnt_ff  <= wave_cnt_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_data_in;
      end
      if (res_load) begin
         res_dout_ff   <= res_dout_in;
         res_pos_ff    <= res_pos_in;
         res_status_ff <= res_status_in;
         res_count_ff  <= count_in;
         res_empty_ff  <= res_empty_in;
         res_full_ff   <= res_full_in;
      end
      if (res_move) begin
         rsp_data_out       <= res_dout_ff;
         rsp_match_position <= bcd_pkg::POS_W'(res_pos_ff);
         rsp_status         <= res_status_ff;
         rsp_entry_count    <= bcd_pkg::COUNT_W'(res_count_ff);
         rsp_is_empty_flag  <= res_empty_ff;
         rsp_is_full_flag   <= res_full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_wave_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcd_pkg::ST_WAVE) |-> (wave_cnt_ff <= DEPTH_C))
      else $error("wave counter overran the chain");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(accept) || $past(wave_done) || $past(reset)))
      else $error("entry count changed without an item or a finished wave");

   a_res_kept: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && !res_move) |=> res_valid_ff)
      else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== sv/bcd_cell.sv =====
// ----------------------------------------------------------------------------
// bcd_cell
// One slot of the deque. Holds the entry at its position from the front,
// shifts with its neighbours on front pushes and pops, and forwards two
// registered wave values: the last search match so far and the rear byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_cell #(
   parameter int DEPTH = bcd_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  wire  bcd_pkg::cell_ctrl_type ctrl,
   input  wire  [$clog2(DEPTH+1)-1:0]   count,
   input  wire  [$clog2(DEPTH+1)-1:0]   target,
   input  wire  [bcd_pkg::BYTE_W-1:0]   left_byte,
   input  wire  [bcd_pkg::BYTE_W-1:0]   right_byte,
   input  wire  [$clog2(DEPTH+1)-1:0]   pos_prev,
   input  wire  [bcd_pkg::BYTE_W-1:0]   rbyte_prev,
   output logic [bcd_pkg::BYTE_W-1:0]   byte_out,
   output logic [$clog2(DEPTH+1)-1:0]   pos_next,
   output logic [bcd_pkg::BYTE_W-1:0]   rbyte_next
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] MY_SLOT = CW'(INDEX);
   localparam logic [CW-1:0] MY_POS  = CW'(INDEX + 1);

   logic [bcd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [CW-1:0]              pos_ff, pos_in;
   logic [bcd_pkg::BYTE_W-1:0] rbyte_ff, rbyte_in;
   logic                       occupied;

   always_comb begin
      byte_in = byte_ff;
      case (ctrl.op)
         bcd_pkg::CELL_SHR:  byte_in = left_byte;
         bcd_pkg::CELL_SHL:  byte_in = right_byte;
         bcd_pkg::CELL_LOAD: begin
            if (target == MY_SLOT) begin
               byte_in = ctrl.wdata;
            end
         end
         default:            byte_in = byte_ff;
      endcase
   end

   // later matches override earlier ones, so the wave ends with the last one
   assign occupied = MY_SLOT < count;
   assign pos_in   = (occupied && (byte_ff == ctrl.key)) ? MY_POS : pos_prev;
   assign rbyte_in = (count == MY_POS) ? byte_ff : rbyte_prev;

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      pos_ff   <= pos_in;
      rbyte_ff <= rbyte_in;
   end

   assign byte_out   = byte_ff;
   assign pos_next   = pos_ff;
   assign rbyte_next = rbyte_ff;

endmodule

`default_nettype wire
